// ===== design/rgfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgfd_pkg: shared types and constants of the RTP GSM frame deframer
// Status codes, header constants and the structs passed to the checker.
// ----------------------------------------------------------------------------
package rgfd_pkg;

  typedef enum logic [3:0] {
    StOk         = 4'd0,
    StShort      = 4'd1,
    StVersion    = 4'd2,
    StCsrc       = 4'd3,
    StExtShort   = 4'd4,
    StExtOverrun = 4'd5,
    StPadding    = 4'd6,
    StFrLength   = 4'd7,
    StType       = 4'd8,
    StOversize   = 4'd9
  } status_e;

  typedef enum logic [0:0] {
    KindFull = 1'b0,
    KindEfr  = 1'b1
  } kind_e;

  // Register map (word index)
  localparam logic [0:0] RegCallRef = 1'b0;

  localparam logic [11:0] HdrBytes  = 12'd12;
  localparam logic [11:0] XhdrBytes = 12'd4;
  localparam logic [11:0] FullLen   = 12'd33;
  localparam logic [6:0]  PtFull    = 7'd3;
  localparam logic [6:0]  PtEfr     = 7'd97;
  localparam logic [1:0]  RtpVer    = 2'd2;

  // Packet state after the latest word has been taken
  typedef struct packed {
    logic [11:0] count;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] ext;
    logic [7:0]  latest;
    logic        oversize;
  } pkt_t;

  // Verdict on a finished packet
  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [11:0] offset;
    logic [11:0] length;
  } verdict_t;

endpackage

// ===== design/rgfd_in_if.sv =====
// ----------------------------------------------------------------------------
// rgfd_in_if: packet byte channel
// Valid/ready channel carrying one packet byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface rgfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// ===== design/rgfd_out_if.sv =====
// ----------------------------------------------------------------------------
// rgfd_out_if: frame descriptor channel
// Valid/ready channel carrying one frame descriptor per packet.
// ----------------------------------------------------------------------------
interface rgfd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        frame_kind;
  logic [11:0] payload_offset;
  logic [11:0] payload_length;
  logic [31:0] frame_call_ref;

  modport source (output valid, output status, output frame_kind, output payload_offset,
                  output payload_length, output frame_call_ref, input ready);
  modport sink   (input valid, input status, input frame_kind, input payload_offset,
                  input payload_length, input frame_call_ref, output ready);
endinterface

// ===== design/rtp_gsm_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// rtp_gsm_frame_deframer_unit: RTP header parser for GSM voice frames
// Parses an RTP packet byte by byte and reports one descriptor per packet.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one packet word per handshake: data_byte in wire order and
//   end_of_packet on the final byte. out_o carries one frame descriptor per
//   packet: status, frame_kind, payload_offset, payload_length and the call
//   reference. Bytes other than the final one give no descriptor.
//   The APB port holds call_reference at byte address 0; it is copied into
//   every descriptor and should be written while no packet is in flight.
// Timing:
//   One byte is accepted per cycle while no final byte is held. A byte waits
//   in the input stage, where the packet counters update and, on the final
//   byte, the checker runs; the descriptor is then registered in the result
//   register and shows on out_o from there. The input stage and the result
//   register lie between an accepted final byte and its descriptor.
// Reset and stall:
//   Reset clears the packet state, the call reference and both stages.
//   While out_o is stalled with a descriptor waiting, non-final bytes still
//   flow; a final byte holds in the input stage until the descriptor is
//   taken, and in_i.ready drops meanwhile.
//   Packets longer than MAX_PACKET_BYTES report oversize.
// ----------------------------------------------------------------------------
module rtp_gsm_frame_deframer_unit
  import rgfd_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgfd_in_if.sink       in_i,
  rgfd_out_if.source    out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic [11:0] MaxCount = 12'(MAX_PACKET_BYTES);

  logic [31:0] call_ref_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_eop_q;
  logic        s1_fire;
  pkt_t        pkt_q;
  pkt_t        pkt_d;
  logic [11:0] xpos;
  verdict_t    verdict;
  logic        out_valid_q;
  verdict_t    out_q;
  logic [31:0] out_ref_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCallRef) ? call_ref_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      call_ref_q <= 32'd0;
    end else if (psel && penable && pwrite && (paddr[2] == RegCallRef)) begin
      call_ref_q <= pwdata;
    end
  end

  // Advance the input stage unless a final word would overwrite a waiting result
  assign s1_fire     = s1_valid_q && (!s1_eop_q || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_eop_q   <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
      s1_eop_q   <= in_i.end_of_packet;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
    end
  end

  // Take the staged byte into the packet state
  assign xpos = HdrBytes + {6'd0, pkt_q.b0[3:0], 2'b00};

  always_comb begin
    pkt_d        = pkt_q;
    pkt_d.latest = s1_byte_q;
    if (pkt_q.count >= MaxCount) begin
      pkt_d.oversize = 1'b1;
    end else begin
      if (pkt_q.count == 12'd0) begin
        pkt_d.b0 = s1_byte_q;
      end else if (pkt_q.count == 12'd1) begin
        pkt_d.b1 = s1_byte_q;
      end else if ((pkt_q.count >= HdrBytes) && (pkt_q.count == xpos + 12'd2)) begin
        pkt_d.ext[15:8] = s1_byte_q;
      end else if ((pkt_q.count >= HdrBytes) && (pkt_q.count == xpos + 12'd3)) begin
        pkt_d.ext[7:0] = s1_byte_q;
      end
      pkt_d.count = pkt_q.count + 12'd1;
    end
  end

  // Hold packet state; clear after the final word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else if (s1_fire) begin
      pkt_q <= s1_eop_q ? '0 : pkt_d;
    end
  end

  rgfd_judge u_judge (
    .pkt_i     (pkt_d),
    .verdict_o (verdict)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_eop_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_eop_q) begin
      out_q     <= verdict;
      out_ref_q <= call_ref_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.frame_kind     = out_q.kind;
  assign out_o.payload_offset = out_q.offset;
  assign out_o.payload_length = out_q.length;
  assign out_o.frame_call_ref = out_ref_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_q.count <= MaxCount)
    else $error("byte count beyond maximum packet size");

  a_oversize_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_q.oversize |-> (pkt_q.count == MaxCount))
    else $error("oversize flagged before packet reached maximum size");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_eop_q))
    else $error("descriptor raised without a final word");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != StOk)) |->
      ((out_q.offset == 12'd0) && (out_q.length == 12'd0) && (out_q.kind == KindFull)))
    else $error("error descriptor carries payload fields");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q) && $stable(out_ref_q)))
    else $error("waiting descriptor changed under stall");

endmodule

// ===== design/rgfd_judge.sv =====
// ----------------------------------------------------------------------------
// rgfd_judge: packet checker
// Runs the header checks on a finished packet in priority order and gives
// the status, frame kind and payload position.
// ----------------------------------------------------------------------------
module rgfd_judge
  import rgfd_pkg::*;
(
  input  pkt_t     pkt_i,
  output verdict_t verdict_o
);

  logic [11:0] pos;
  logic [11:0] rest;
  logic [18:0] xlen;
  logic [11:0] pos_e;
  logic [11:0] rest_e;
  logic [11:0] rest_p;
  logic [6:0]  pt;

  // Payload position arithmetic
  always_comb begin
    pos    = HdrBytes + {6'd0, pkt_i.b0[3:0], 2'b00};
    rest   = pkt_i.count - pos;
    xlen   = {1'b0, pkt_i.ext, 2'b00} + 19'(XhdrBytes);
    pos_e  = pkt_i.b0[4] ? (pos + xlen[11:0]) : pos;
    rest_e = pkt_i.b0[4] ? (rest - xlen[11:0]) : rest;
    rest_p = pkt_i.b0[5] ? (rest_e - {4'd0, pkt_i.latest}) : rest_e;
    pt     = pkt_i.b1[6:0];
  end

  // Checks, first failure wins
  always_comb begin
    verdict_o = '0;
    verdict_o.status = StOk;
    verdict_o.kind   = KindFull;
    if (pkt_i.oversize) begin
      verdict_o.status = StOversize;
    end else if (pkt_i.count < HdrBytes) begin
      verdict_o.status = StShort;
    end else if (pkt_i.b0[7:6] != RtpVer) begin
      verdict_o.status = StVersion;
    end else if (pos > pkt_i.count) begin
      verdict_o.status = StCsrc;
    end else if (pkt_i.b0[4] && (rest < XhdrBytes)) begin
      verdict_o.status = StExtShort;
    end else if (pkt_i.b0[4] && (xlen > {7'd0, rest})) begin
      verdict_o.status = StExtOverrun;
    end else if (pkt_i.b0[5] && ((rest_e == 12'd0) || ({4'd0, pkt_i.latest} > rest_e))) begin
      verdict_o.status = StPadding;
    end else if (pt == PtFull) begin
      if (rest_p != FullLen) begin
        verdict_o.status = StFrLength;
      end else begin
        verdict_o.kind   = KindFull;
        verdict_o.offset = pos_e;
        verdict_o.length = rest_p;
      end
    end else if (pt == PtEfr) begin
      verdict_o.kind   = KindEfr;
      verdict_o.offset = pos_e;
      verdict_o.length = rest_p;
    end else begin
      verdict_o.status = StType;
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: RTP GSM frame deframer check
// Streams RTP packets into the deframer byte by byte, predicts each frame
// descriptor from the packet bytes and compares every field on the way out.
// Runs directed packets for each status code, then random packets under
// several sender and receiver idle patterns, with call reference changes
// between phases.
// ----------------------------------------------------------------------------
module testbench;
  import rgfd_pkg::*;

  localparam int MaxPacketBytes = 2048;
  localparam logic [2:0] CallRefAddr = {RegCallRef, 2'b00};

  typedef struct {
    status_e     status;
    kind_e       kind;
    logic [11:0] offset;
    logic [11:0] length;
    logic [31:0] call_ref;
  } frame_desc_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rgfd_in_if  byte_bus ();
  rgfd_out_if frame_bus ();

  rtp_gsm_frame_deframer_unit #(
    .MAX_PACKET_BYTES(MaxPacketBytes)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus),
    .out_o  (frame_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Packet state as the block should hold it
  logic [11:0] pk_count    = '0;
  logic [7:0]  pk_b0       = '0;
  logic [7:0]  pk_b1       = '0;
  logic [15:0] pk_ext      = '0;
  logic [7:0]  pk_latest   = '0;
  logic        pk_oversize = 1'b0;
  logic [31:0] call_ref_model = '0;

  frame_desc_t pending_frames[$];
  logic [7:0]  pkt_bytes[$];

  int error_count      = 0;
  int bytes_accepted   = 0;
  int frames_predicted = 0;
  int sender_idle_pct  = 0;
  int receiver_stall_pct = 0;
  int hold_cycles      = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #4_000_000;
    $display("** rtp_gsm_frame_deframer_unit: FAILED **");
    $finish;
  end

  // Receiver: stall at random, or hold off for a counted stretch on request
  initial begin
    frame_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        frame_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        frame_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Check each descriptor taken against the oldest prediction
  initial begin
    frame_desc_t exp_frame;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_bus.valid && frame_bus.ready) begin
        if (pending_frames.size() == 0) begin
          $error("frame descriptor with none expected: status %0d", frame_bus.status);
          error_count++;
        end else begin
          exp_frame = pending_frames.pop_front();
          if (frame_bus.status !== exp_frame.status) begin
            $error("status: expected %0d, got %0d", exp_frame.status, frame_bus.status);
            error_count++;
          end
          if (frame_bus.frame_kind !== exp_frame.kind) begin
            $error("frame_kind: expected %0d, got %0d", exp_frame.kind, frame_bus.frame_kind);
            error_count++;
          end
          if (frame_bus.payload_offset !== exp_frame.offset) begin
            $error("payload_offset: expected %0d, got %0d", exp_frame.offset,
                   frame_bus.payload_offset);
            error_count++;
          end
          if (frame_bus.payload_length !== exp_frame.length) begin
            $error("payload_length: expected %0d, got %0d", exp_frame.length,
                   frame_bus.payload_length);
            error_count++;
          end
          if (frame_bus.frame_call_ref !== exp_frame.call_ref) begin
            $error("frame_call_ref: expected %h, got %h", exp_frame.call_ref,
                   frame_bus.frame_call_ref);
            error_count++;
          end
        end
      end
    end
  end

  // Verdict on the finished packet; kind, offset and length stay zero on error
  function automatic status_e judge_packet(output kind_e kind, output int offset,
                                           output int length);
    int n;
    int pos;
    int rest;
    int xlen;
    kind   = KindFull;
    offset = 0;
    length = 0;
    n = int'(pk_count);
    if (pk_oversize) return StOversize;
    if (n < int'(HdrBytes)) return StShort;
    if (pk_b0[7:6] != RtpVer) return StVersion;
    pos = int'(HdrBytes) + 4 * int'(pk_b0[3:0]);
    if (pos > n) return StCsrc;
    rest = n - pos;
    // Skip the extension header and its words
    if (pk_b0[4]) begin
      if (rest < int'(XhdrBytes)) return StExtShort;
      xlen = 4 * int'(pk_ext) + int'(XhdrBytes);
      if (xlen > rest) return StExtOverrun;
      pos  += xlen;
      rest -= xlen;
    end
    // Drop padding; its count is the final byte
    if (pk_b0[5]) begin
      if (rest == 0 || int'(pk_latest) > rest) return StPadding;
      rest -= int'(pk_latest);
    end
    if (pk_b1[6:0] == PtFull) begin
      if (rest != int'(FullLen)) return StFrLength;
      kind = KindFull;
    end else if (pk_b1[6:0] == PtEfr) begin
      kind = KindEfr;
    end else begin
      return StType;
    end
    offset = pos;
    length = rest;
    return StOk;
  endfunction

  // Advance the packet state by one byte; predict a descriptor on the final one
  function automatic void absorb_packet_byte(input logic [7:0] value, input logic last);
    int          xpos;
    kind_e       kind;
    int          offset;
    int          length;
    frame_desc_t desc;
    xpos = int'(HdrBytes) + 4 * int'(pk_b0[3:0]);
    pk_latest = value;
    if (int'(pk_count) >= MaxPacketBytes) begin
      pk_oversize = 1'b1;
    end else begin
      if (pk_count == 12'd0) pk_b0 = value;
      else if (pk_count == 12'd1) pk_b1 = value;
      else if (pk_count >= HdrBytes && int'(pk_count) == xpos + 2) pk_ext[15:8] = value;
      else if (pk_count >= HdrBytes && int'(pk_count) == xpos + 3) pk_ext[7:0] = value;
      pk_count = pk_count + 12'd1;
    end
    if (last) begin
      desc.status   = judge_packet(kind, offset, length);
      desc.kind     = kind;
      desc.offset   = 12'(offset);
      desc.length   = 12'(length);
      desc.call_ref = call_ref_model;
      pending_frames.push_back(desc);
      frames_predicted++;
      pk_count    = '0;
      pk_b0       = '0;
      pk_b1       = '0;
      pk_ext      = '0;
      pk_latest   = '0;
      pk_oversize = 1'b0;
    end
  endfunction

  // Offer one word after a random gap and hold it until the block takes it
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid         <= 1'b1;
    byte_bus.data_byte     <= value;
    byte_bus.end_of_packet <= last;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    bytes_accepted++;
    absorb_packet_byte(value, last);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  function automatic void add_byte(input logic [7:0] value);
    pkt_bytes.push_back(value);
  endfunction

  function automatic void add_random(input int count);
    repeat (count) pkt_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_fill(input int count, input logic [7:0] value);
    repeat (count) pkt_bytes.push_back(value);
  endfunction

  // Begin a packet with the two leading bytes and ten random header bytes
  function automatic void start_header(input logic [7:0] b0, input logic [7:0] b1);
    pkt_bytes = {};
    pkt_bytes.push_back(b0);
    pkt_bytes.push_back(b1);
    add_random(10);
  endfunction

  // Mostly well-formed packets with random content; some noise and breakage
  function automatic void build_random_packet();
    int         style;
    int         csrc;
    int         ext_len;
    int         payload;
    int         pad;
    int         pick;
    logic       has_ext;
    logic       has_pad;
    logic [6:0] ptype;
    style = $urandom_range(99);
    if (style < 8) begin
      pkt_bytes = {};
      add_random($urandom_range(1, 30));
      return;
    end
    csrc    = ($urandom_range(99) < 80) ? $urandom_range(2) : $urandom_range(15);
    has_ext = ($urandom_range(99) < 30);
    has_pad = ($urandom_range(99) < 25);
    pick    = $urandom_range(99);
    ptype   = (pick < 45) ? PtFull : (pick < 90) ? PtEfr : 7'($urandom);
    start_header({RtpVer, has_pad, has_ext, 4'(csrc)}, {1'($urandom), ptype});
    add_random(4 * csrc);
    if (has_ext) begin
      ext_len = $urandom_range(3);
      add_random(2);
      add_byte(8'(ext_len >> 8));
      add_byte(8'(ext_len));
      add_random(4 * ext_len);
    end
    if (ptype == PtFull) begin
      payload = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : int'(FullLen);
    end else begin
      payload = $urandom_range(40);
    end
    add_random(payload);
    if (has_pad) begin
      pad = $urandom_range(1, 4);
      add_random(pad - 1);
      add_byte(8'(pad));
    end
    // Break a few: cut short, or spoil the version
    if (style < 12) begin
      pick = $urandom_range(pkt_bytes.size() - 1);
      while (pkt_bytes.size() > pick + 1) void'(pkt_bytes.pop_back());
    end else if (style < 16) begin
      pkt_bytes[0][7:6] = 2'($urandom);
    end
  endfunction

  // Drop valid, wait out every predicted descriptor, then the pipeline latency
  task automatic drain_frames();
    int guard;
    guard = 0;
    byte_bus.valid <= 1'b0;
    while (pending_frames.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_call_ref(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CallRefAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    call_ref_model = value;
  endtask

  // Short packets and an all-zero header, with the call reference at reset
  task automatic test_reset_state();
    pkt_bytes = {};
    add_fill(1, 8'h00);
    send_packet();
    pkt_bytes = {};
    add_fill(11, 8'hFF);
    send_packet();
    pkt_bytes = {};
    add_fill(12, 8'h00);
    send_packet();
    drain_frames();
  endtask

  // Version and CSRC list checks
  task automatic test_header_checks();
    start_header(8'h40, 8'h61);
    add_random(4);
    send_packet();
    start_header(8'hFF, 8'h61);
    add_random(4);
    send_packet();
    start_header(8'h8F, 8'h61);
    add_random(8);
    send_packet();
    start_header(8'h81, 8'h61);
    add_random(4);
    send_packet();
    start_header(8'h80, 8'h61);
    send_packet();
    drain_frames();
  endtask

  // Extension header and padding handling
  task automatic test_extension_and_padding();
    // No room for the extension header
    start_header(8'h90, 8'h61);
    add_random(2);
    send_packet();
    // Extension length runs past the packet
    start_header(8'h90, 8'h61);
    add_random(2);
    add_fill(2, 8'hFF);
    add_random(4);
    send_packet();
    // One extension word, then a short EFR payload
    start_header(8'h90, 8'h61);
    add_random(2);
    add_byte(8'h00);
    add_byte(8'h01);
    add_random(4 + 5);
    send_packet();
    // Extension bit clear: bytes at the extension spot are payload
    start_header(8'h80, 8'h61);
    add_fill(20, 8'hFF);
    send_packet();
    // Padding with an empty payload
    start_header(8'hA0, 8'h61);
    send_packet();
    // Padding count larger than the payload
    start_header(8'hA0, 8'h61);
    add_random(2);
    add_byte(8'hFF);
    send_packet();
    // Padding count of zero
    start_header(8'hA0, 8'h61);
    add_random(4);
    add_byte(8'h00);
    send_packet();
    // Padded full-rate frame
    start_header(8'hA0, 8'h03);
    add_random(35);
    add_byte(8'h03);
    send_packet();
    drain_frames();
  endtask

  // Payload type and full-rate length checks
  task automatic test_payload_types();
    start_header(8'h80, 8'h83);
    add_random(int'(FullLen));
    send_packet();
    start_header(8'h80, 8'h03);
    add_random(int'(FullLen) - 1);
    send_packet();
    start_header(8'h80, 8'h03);
    add_random(int'(FullLen) + 1);
    send_packet();
    start_header(8'h80, 8'hE1);
    send_packet();
    start_header(8'h80, 8'h00);
    add_random(int'(FullLen));
    send_packet();
    start_header(8'h80, 8'hFF);
    add_random(3);
    send_packet();
    drain_frames();
  endtask

  // Largest legal packet, and one over the limit that also has a bad version
  task automatic test_packet_size_limits();
    start_header(8'h80, 8'h61);
    add_random(MaxPacketBytes - 12);
    send_packet();
    start_header(8'h00, 8'h03);
    add_random(MaxPacketBytes + 1 - 12);
    send_packet();
    drain_frames();
  endtask

  // Hold the receiver off while packets keep coming, so the input stalls
  task automatic test_output_stall();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_cycles        = 300;
    repeat (24) begin
      start_header(8'h80, ($urandom_range(1) != 0) ? 8'h61 : 8'h03);
      add_random($urandom_range(6));
      send_packet();
    end
    drain_frames();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int byte_budget, input int min_frames);
    int byte_mark;
    int frame_mark;
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    byte_mark  = bytes_accepted;
    frame_mark = frames_predicted;
    while (bytes_accepted - byte_mark < byte_budget ||
           frames_predicted - frame_mark < min_frames) begin
      build_random_packet();
      send_packet();
    end
    drain_frames();
  endtask

  // Sequence
  initial begin
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    byte_bus.valid         <= 1'b0;
    byte_bus.data_byte     <= '0;
    byte_bus.end_of_packet <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_state();
    write_call_ref(32'hFFFF_FFFF);
    test_header_checks();
    write_call_ref(32'h0000_0000);
    test_extension_and_padding();
    write_call_ref(32'h8000_0001);
    test_payload_types();
    write_call_ref($urandom);
    test_packet_size_limits();
    write_call_ref($urandom);
    test_output_stall();

    write_call_ref(32'hFFFF_FFFF);
    test_random_traffic(0, 0, 300, 15);
    write_call_ref($urandom);
    test_random_traffic(70, 0, 300, 15);
    write_call_ref(32'h0000_0000);
    test_random_traffic(0, 70, 300, 15);
    write_call_ref($urandom);
    test_random_traffic(34, 34, 300, 15);

    drain_frames();
    if (pending_frames.size() != 0) begin
      $error("%0d frame descriptors never arrived", pending_frames.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** rtp_gsm_frame_deframer_unit: PASSED **");
    end else begin
      $display("** rtp_gsm_frame_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
